// File: rtl/bnms_pkg.sv
// ----------------------------------------------------------------------------
// bnms_pkg: shared types and constants of box non-maximum suppression
// Default sizes, register map, controller and overlap unit state types.
// ----------------------------------------------------------------------------
package bnms_pkg;

    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;
    localparam int CLASS_BITS_DEF = 8;

    localparam int CONF_BITS = 16;
    localparam int THR_BITS  = 16;
    localparam logic [THR_BITS-1:0] THR_RESET = 16'd29491;

    // register index as seen on paddr[2]
    localparam logic REG_IOU_THR = 1'b0;

    typedef enum logic [3:0] {
        CTL_IDLE,
        CTL_INS,
        CTL_INS_WAIT,
        CTL_SCAN,
        CTL_SCAN_RD,
        CTL_SCAN_BOX,
        CTL_EMIT,
        CTL_CMP,
        CTL_CMP_RD,
        CTL_CMP_BOX,
        CTL_IOU,
        CTL_FLUSH
    } t_ctl_state;

    typedef enum logic [2:0] {
        IOU_IDLE,
        IOU_INTER,
        IOU_AREA_A,
        IOU_AREA_B,
        IOU_UNION,
        IOU_THR,
        IOU_CMP
    } t_iou_state;

    typedef struct packed {
        logic done;
        logic hit;
    } t_iou_res;

endpackage

// File: rtl/box_non_max_suppression.sv
// ----------------------------------------------------------------------------
// box_non_max_suppression: greedy per-class non-maximum suppression
// Loads candidates into ram, keeps them ordered by confidence, then walks
// the order and suppresses same-class overlaps through one shared unit.
// ----------------------------------------------------------------------------
// load: each candidate is stored, then the insertion sort shifts lower ranked
// entries down, one sort ram read and write per shift step
// closing the set: every position is scanned; for every kept box, each later
// position is read and a same-class overlap test runs on the shared multiplier
// reset clears the controller, the counts and the threshold (29491); rams
// hold no reset state and need no clearing pass
// ----------------------------------------------------------------------------
module box_non_max_suppression
    import bnms_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int CLASS_BITS = CLASS_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // candidate channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_BITS-1:0] i_box_left,
    input  logic [COORD_BITS-1:0] i_box_top,
    input  logic [COORD_BITS-1:0] i_box_right,
    input  logic [COORD_BITS-1:0] i_box_bottom,
    input  logic [CLASS_BITS-1:0] i_class_label,
    input  logic [CONF_BITS-1:0]  i_confidence,
    input  logic                  i_final_candidate,
    // kept box channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_kept_left,
    output logic [COORD_BITS-1:0] o_kept_top,
    output logic [COORD_BITS-1:0] o_kept_right,
    output logic [COORD_BITS-1:0] o_kept_bottom,
    output logic [CLASS_BITS-1:0] o_kept_class,
    output logic [CONF_BITS-1:0]  o_kept_confidence,
    output logic                  o_overflowed,
    output logic                  o_last_kept,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int IW  = $clog2(MAX_BOXES);
    localparam int CW  = $clog2(MAX_BOXES + 1);
    localparam int BXW = 4 * COORD_BITS;
    localparam int BW  = BXW + CLASS_BITS;
    localparam int SW  = CONF_BITS + IW;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [THR_BITS-1:0] r_thr;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IOU_THR) ? 32'(r_thr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_IOU_THR) begin
            r_thr <= pwdata[THR_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // storage: box ram by load slot, sort ram {confidence, slot} by rank,
    // suppress flag ram by rank
    // ------------------------------------------------------------------
    logic          box_we, sort_we, supp_we;
    logic [IW-1:0] box_waddr, box_raddr, sort_waddr, sort_raddr;
    logic [IW-1:0] supp_waddr, supp_raddr;
    logic [BW-1:0] box_wdata, box_rdata;
    logic [SW-1:0] sort_wdata, sort_rdata;
    logic          supp_wdata, supp_rdata;

    bnms_ram #(.WIDTH(BW), .DEPTH(MAX_BOXES)) u_box_ram (
        .i_clk   (i_clk),
        .i_we    (box_we),
        .i_waddr (box_waddr),
        .i_wdata (box_wdata),
        .i_raddr (box_raddr),
        .o_rdata (box_rdata)
    );

    bnms_ram #(.WIDTH(SW), .DEPTH(MAX_BOXES)) u_sort_ram (
        .i_clk   (i_clk),
        .i_we    (sort_we),
        .i_waddr (sort_waddr),
        .i_wdata (sort_wdata),
        .i_raddr (sort_raddr),
        .o_rdata (sort_rdata)
    );

    bnms_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_supp_ram (
        .i_clk   (i_clk),
        .i_we    (supp_we),
        .i_waddr (supp_waddr),
        .i_wdata (supp_wdata),
        .i_raddr (supp_raddr),
        .o_rdata (supp_rdata)
    );

    logic [CONF_BITS-1:0] rd_conf;
    logic [IW-1:0]        rd_slot;
    assign rd_conf = sort_rdata[SW-1:IW];
    assign rd_slot = sort_rdata[IW-1:0];

    // ------------------------------------------------------------------
    // overlap unit, box a is the current kept box, box b comes from ram
    // ------------------------------------------------------------------
    logic     iou_start;
    t_iou_res iou_res;
    logic [BXW-1:0] r_cur_box, n_cur_box;
    logic [CLASS_BITS-1:0] r_cur_class, n_cur_class;
    logic [CONF_BITS-1:0]  r_cur_conf, n_cur_conf;

    bnms_iou #(.COORD_BITS(COORD_BITS)) u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (iou_start),
        .i_box_a (r_cur_box),
        .i_box_b (box_rdata[BXW-1:0]),
        .i_thr   (r_thr),
        .o_res   (iou_res)
    );

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    t_ctl_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [IW-1:0] r_pos, n_pos;
    logic [CONF_BITS-1:0] r_new_conf, n_new_conf;
    logic [IW-1:0] r_new_slot, n_new_slot;
    logic          r_fin, n_fin;
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic [CONF_BITS-1:0] r_sel_conf, n_sel_conf;

    // pending kept box: held back until we know whether it is the last one
    logic                  r_pend_v, n_pend_v;
    logic [BXW-1:0]        r_pend_box, n_pend_box;
    logic [CLASS_BITS-1:0] r_pend_class, n_pend_class;
    logic [CONF_BITS-1:0]  r_pend_conf, n_pend_conf;

    // output register
    logic                  r_out_valid;
    logic [BXW-1:0]        r_out_box;
    logic [CLASS_BITS-1:0] r_out_class;
    logic [CONF_BITS-1:0]  r_out_conf;
    logic                  r_out_ovf, r_out_last;
    logic                  out_load, out_last;
    logic                  out_free;
    logic                  in_acc;

    assign o_in_stall = (r_state != CTL_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_pos        = r_pos;
        n_new_conf   = r_new_conf;
        n_new_slot   = r_new_slot;
        n_fin        = r_fin;
        n_i          = r_i;
        n_j          = r_j;
        n_sel_conf   = r_sel_conf;
        n_cur_box    = r_cur_box;
        n_cur_class  = r_cur_class;
        n_cur_conf   = r_cur_conf;
        n_pend_v     = r_pend_v;
        n_pend_box   = r_pend_box;
        n_pend_class = r_pend_class;
        n_pend_conf  = r_pend_conf;
        box_we       = 1'b0;
        box_waddr    = r_count[IW-1:0];
        box_wdata    = {i_class_label, i_box_bottom, i_box_right, i_box_top, i_box_left};
        box_raddr    = rd_slot;
        sort_we      = 1'b0;
        sort_waddr   = r_pos;
        sort_wdata   = {r_new_conf, r_new_slot};
        sort_raddr   = r_pos - 1'b1;
        supp_we      = 1'b0;
        supp_waddr   = r_count[IW-1:0];
        supp_wdata   = 1'b0;
        supp_raddr   = r_i[IW-1:0];
        iou_start    = 1'b0;
        out_load     = 1'b0;
        out_last     = 1'b0;

        unique case (r_state)
            CTL_IDLE: begin
                if (in_acc) begin
                    if (r_count < CW'(MAX_BOXES)) begin
                        // store box, clear its suppress flag, start insertion
                        box_we     = 1'b1;
                        supp_we    = 1'b1;
                        n_new_conf = i_confidence;
                        n_new_slot = r_count[IW-1:0];
                        n_pos      = r_count[IW-1:0];
                        n_fin      = i_final_candidate;
                        n_state    = CTL_INS;
                    end else begin
                        // dropped, but a final flag still closes the set
                        n_ovf = 1'b1;
                        if (i_final_candidate) begin
                            n_i     = '0;
                            n_state = CTL_SCAN;
                        end
                    end
                end
            end
            CTL_INS: begin
                if (r_pos == '0) begin
                    sort_we = 1'b1;
                    n_count = r_count + 1'b1;
                    n_i     = '0;
                    n_state = r_fin ? CTL_SCAN : CTL_IDLE;
                end else begin
                    n_state = CTL_INS_WAIT;
                end
            end
            CTL_INS_WAIT: begin
                sort_we = 1'b1;
                if (rd_conf < r_new_conf) begin
                    // shift the lower ranked entry down by one
                    sort_wdata = sort_rdata;
                    n_pos      = r_pos - 1'b1;
                    n_state    = CTL_INS;
                end else begin
                    // ties stay ahead of the new entry
                    n_count = r_count + 1'b1;
                    n_i     = '0;
                    n_state = r_fin ? CTL_SCAN : CTL_IDLE;
                end
            end
            CTL_SCAN: begin
                sort_raddr = r_i[IW-1:0];
                supp_raddr = r_i[IW-1:0];
                n_state    = (r_i == r_count) ? CTL_FLUSH : CTL_SCAN_RD;
            end
            CTL_SCAN_RD: begin
                if (supp_rdata) begin
                    n_i     = r_i + 1'b1;
                    n_state = CTL_SCAN;
                end else begin
                    n_sel_conf = rd_conf;
                    n_state    = CTL_SCAN_BOX;
                end
            end
            CTL_SCAN_BOX: begin
                n_cur_box   = box_rdata[BXW-1:0];
                n_cur_class = box_rdata[BW-1:BXW];
                n_cur_conf  = r_sel_conf;
                n_state     = CTL_EMIT;
            end
            CTL_EMIT: begin
                if (!r_pend_v || out_free) begin
                    out_load     = r_pend_v;
                    n_pend_v     = 1'b1;
                    n_pend_box   = r_cur_box;
                    n_pend_class = r_cur_class;
                    n_pend_conf  = r_cur_conf;
                    n_j          = r_i + 1'b1;
                    n_state      = CTL_CMP;
                end
            end
            CTL_CMP: begin
                sort_raddr = r_j[IW-1:0];
                supp_raddr = r_j[IW-1:0];
                if (r_j == r_count) begin
                    n_i     = r_i + 1'b1;
                    n_state = CTL_SCAN;
                end else begin
                    n_state = CTL_CMP_RD;
                end
            end
            CTL_CMP_RD: begin
                if (supp_rdata) begin
                    n_j     = r_j + 1'b1;
                    n_state = CTL_CMP;
                end else begin
                    n_state = CTL_CMP_BOX;
                end
            end
            CTL_CMP_BOX: begin
                if (box_rdata[BW-1:BXW] != r_cur_class) begin
                    n_j     = r_j + 1'b1;
                    n_state = CTL_CMP;
                end else begin
                    iou_start = 1'b1;
                    n_state   = CTL_IOU;
                end
            end
            CTL_IOU: begin
                if (iou_res.done) begin
                    supp_we    = iou_res.hit;
                    supp_waddr = r_j[IW-1:0];
                    supp_wdata = 1'b1;
                    n_j        = r_j + 1'b1;
                    n_state    = CTL_CMP;
                end
            end
            CTL_FLUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = 1'b1;
                    n_pend_v = 1'b0;
                    n_count  = '0;
                    n_ovf    = 1'b0;
                    n_state  = CTL_IDLE;
                end
            end
            default: begin
                n_state = CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CTL_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_pend_v <= n_pend_v;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_new_conf   <= n_new_conf;
        r_new_slot   <= n_new_slot;
        r_fin        <= n_fin;
        r_i          <= n_i;
        r_j          <= n_j;
        r_sel_conf   <= n_sel_conf;
        r_cur_box    <= n_cur_box;
        r_cur_class  <= n_cur_class;
        r_cur_conf   <= n_cur_conf;
        r_pend_box   <= n_pend_box;
        r_pend_class <= n_pend_class;
        r_pend_conf  <= n_pend_conf;
        if (out_load) begin
            r_out_box   <= r_pend_box;
            r_out_class <= r_pend_class;
            r_out_conf  <= r_pend_conf;
            r_out_ovf   <= r_ovf;
            r_out_last  <= out_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kept_left       = r_out_box[COORD_BITS-1:0];
    assign o_kept_top        = r_out_box[2*COORD_BITS-1:COORD_BITS];
    assign o_kept_right      = r_out_box[3*COORD_BITS-1:2*COORD_BITS];
    assign o_kept_bottom     = r_out_box[4*COORD_BITS-1:3*COORD_BITS];
    assign o_kept_class      = r_out_class;
    assign o_kept_confidence = r_out_conf;
    assign o_overflowed      = r_out_ovf;
    assign o_last_kept       = r_out_last;

endmodule

// File: rtl/bnms_ram.sv
// ----------------------------------------------------------------------------
// bnms_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bnms_iou.sv
// ----------------------------------------------------------------------------
// bnms_iou: overlap test with one shared multiplier
// Decides inter * 2^16 > threshold * union for two boxes.
// ----------------------------------------------------------------------------
module bnms_iou
    import bnms_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [4*COORD_BITS-1:0] i_box_a,
    input  logic [4*COORD_BITS-1:0] i_box_b,
    input  logic [THR_BITS-1:0]     i_thr,
    output t_iou_res                o_res
);

    localparam int W  = COORD_BITS;
    localparam int AW = 2 * W;
    localparam int UW = AW + 1;
    localparam int PW = THR_BITS + UW;

    t_iou_state r_state, n_state;
    logic [W-1:0] r_dx, r_dy, r_wa, r_ha, r_wb, r_hb;
    logic [W-1:0] c_dx, c_dy, c_wa, c_ha, c_wb, c_hb;
    logic [W-1:0] al, at, ar, ab, bl, bt, br, bb;
    logic [W-1:0] ix1, iy1, ix2, iy2;
    logic [THR_BITS-1:0] r_thr;
    logic [AW-1:0] r_inter, n_inter, r_area, n_area;
    logic [UW-1:0] r_uni, n_uni;
    logic [PW-1:0] r_prod, n_prod;
    logic [THR_BITS-1:0] opa;
    logic [UW-1:0] opb;
    t_iou_res r_res, n_res;

    assign al = i_box_a[W-1:0];
    assign at = i_box_a[2*W-1:W];
    assign ar = i_box_a[3*W-1:2*W];
    assign ab = i_box_a[4*W-1:3*W];
    assign bl = i_box_b[W-1:0];
    assign bt = i_box_b[2*W-1:W];
    assign br = i_box_b[3*W-1:2*W];
    assign bb = i_box_b[4*W-1:3*W];

    always_comb begin
        ix1  = (al > bl) ? al : bl;
        iy1  = (at > bt) ? at : bt;
        ix2  = (ar < br) ? ar : br;
        iy2  = (ab < bb) ? ab : bb;
        c_dx = (ix2 > ix1) ? ix2 - ix1 : '0;
        c_dy = (iy2 > iy1) ? iy2 - iy1 : '0;
        // inverted sides count as zero width
        c_wa = (ar > al) ? ar - al : '0;
        c_ha = (ab > at) ? ab - at : '0;
        c_wb = (br > bl) ? br - bl : '0;
        c_hb = (bb > bt) ? bb - bt : '0;
    end

    assign n_prod = PW'(opa) * PW'(opb);

    always_comb begin
        n_state = r_state;
        n_inter = r_inter;
        n_area  = r_area;
        n_uni   = r_uni;
        n_res   = '0;
        opa     = '0;
        opb     = '0;
        unique case (r_state)
            IOU_IDLE: begin
                if (i_start) begin
                    n_state = IOU_INTER;
                end
            end
            IOU_INTER: begin
                if (r_dx == '0 || r_dy == '0) begin
                    n_res   = '{done: 1'b1, hit: 1'b0};
                    n_state = IOU_IDLE;
                end else begin
                    opa     = THR_BITS'(r_dx);
                    opb     = UW'(r_dy);
                    n_state = IOU_AREA_A;
                end
            end
            IOU_AREA_A: begin
                n_inter = r_prod[AW-1:0];
                opa     = THR_BITS'(r_wa);
                opb     = UW'(r_ha);
                n_state = IOU_AREA_B;
            end
            IOU_AREA_B: begin
                n_area  = r_prod[AW-1:0];
                opa     = THR_BITS'(r_wb);
                opb     = UW'(r_hb);
                n_state = IOU_UNION;
            end
            IOU_UNION: begin
                n_uni   = UW'(r_area) + UW'(r_prod[AW-1:0]) - UW'(r_inter);
                n_state = IOU_THR;
            end
            IOU_THR: begin
                opa     = r_thr;
                opb     = r_uni;
                n_state = IOU_CMP;
            end
            IOU_CMP: begin
                n_res   = '{done: 1'b1,
                            hit: (PW'({r_inter, {THR_BITS{1'b0}}}) > r_prod)};
                n_state = IOU_IDLE;
            end
            default: begin
                n_state = IOU_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IOU_IDLE;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == IOU_IDLE && i_start) begin
            r_dx  <= c_dx;
            r_dy  <= c_dy;
            r_wa  <= c_wa;
            r_ha  <= c_ha;
            r_wb  <= c_wb;
            r_hb  <= c_hb;
            r_thr <= i_thr;
        end
        r_inter <= n_inter;
        r_area  <= n_area;
        r_uni   <= n_uni;
        r_prod  <= n_prod;
    end

    assign o_res = r_res;

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for box_non_max_suppression
// Streams candidate sets with random handshake gaps, predicts the kept boxes
// with a behavioral greedy per-class suppression and checks every transaction
// on the kept box channel. Threshold is moved between phases over the apb port.
// ----------------------------------------------------------------------------
module testbench;
    import bnms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBOX      = MAX_BOXES_DEF;
    localparam int CW        = COORD_BITS_DEF;
    localparam int LW        = CLASS_BITS_DEF;
    localparam int LIMIT     = 1_000_000;
    localparam int SETTLE    = 400;  // covers one insertion with a full shift

    typedef struct {
        logic [CW-1:0]        l, t, r, b;
        logic [LW-1:0]        cls;
        logic [CONF_BITS-1:0] conf;
        logic                 fin;
    } t_cand;

    typedef struct {
        logic [CW-1:0]        l, t, r, b;
        logic [LW-1:0]        cls;
        logic [CONF_BITS-1:0] conf;
        logic                 ovf;
        logic                 last;
    } t_kept;

    // clock, reset and block ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [CW-1:0]        i_box_left = '0, i_box_top = '0, i_box_right = '0, i_box_bottom = '0;
    logic [LW-1:0]        i_class_label = '0;
    logic [CONF_BITS-1:0] i_confidence = '0;
    logic                 i_final_candidate = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [CW-1:0]        o_kept_left, o_kept_top, o_kept_right, o_kept_bottom;
    logic [LW-1:0]        o_kept_class;
    logic [CONF_BITS-1:0] o_kept_confidence;
    logic                 o_overflowed, o_last_kept;
    logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    always #5 i_clk = ~i_clk;

    box_non_max_suppression u_top (.*);

    // bench state
    t_cand    pending_cands[$];
    t_kept    kept_expected[$];
    t_cand    cur_cand;
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    int       err_count = 0;
    int       cycle_count = 0;
    int       sets_closed = 0;
    int       overflow_sets = 0;
    int       boxes_checked = 0;
    int       items_queued = 0;

    // predictor copy of the block state
    logic [THR_BITS-1:0]  thr_shadow = THR_RESET;
    t_cand                slot_cand [NBOX];
    int                   rank_slot [NBOX];
    bit                   gone_flag [NBOX];
    int                   slot_count = 0;
    bit                   drop_seen = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_count++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    endtask

    // exact iou test by cross multiplication
    function automatic bit iou_exceeds(input t_cand a, input t_cand b);
        longint unsigned ix1, iy1, ix2, iy2, inter, area_a, area_b, uni;
        ix1 = 64'((a.l > b.l) ? a.l : b.l);
        iy1 = 64'((a.t > b.t) ? a.t : b.t);
        ix2 = 64'((a.r < b.r) ? a.r : b.r);
        iy2 = 64'((a.b < b.b) ? a.b : b.b);
        if (ix2 <= ix1 || iy2 <= iy1) return 1'b0;
        inter  = (ix2 - ix1) * (iy2 - iy1);
        area_a = 64'((a.r > a.l) ? a.r - a.l : CW'(0)) * 64'((a.b > a.t) ? a.b - a.t : CW'(0));
        area_b = 64'((b.r > b.l) ? b.r - b.l : CW'(0)) * 64'((b.b > b.t) ? b.b - b.t : CW'(0));
        uni    = area_a + area_b - inter;
        return (inter * 64'd65536) > (64'(thr_shadow) * uni);
    endfunction

    // take one accepted candidate; on the closing one, queue the kept boxes
    task automatic absorb_candidate(input t_cand c);
        int pos, n, nkept;
        t_kept k;
        if (slot_count < NBOX) begin
            pos = slot_count;
            slot_cand[slot_count] = c;
            // stable insertion: ties stay in load order
            while (pos > 0 && slot_cand[rank_slot[pos-1]].conf < c.conf) begin
                rank_slot[pos] = rank_slot[pos-1];
                pos--;
            end
            rank_slot[pos] = slot_count;
            slot_count++;
        end else begin
            drop_seen = 1;
        end
        if (!c.fin) return;
        n = slot_count;
        nkept = 0;
        for (int i = 0; i < n; i++) begin
            if (gone_flag[i]) continue;
            k.l = slot_cand[rank_slot[i]].l;
            k.t = slot_cand[rank_slot[i]].t;
            k.r = slot_cand[rank_slot[i]].r;
            k.b = slot_cand[rank_slot[i]].b;
            k.cls = slot_cand[rank_slot[i]].cls;
            k.conf = slot_cand[rank_slot[i]].conf;
            k.ovf = drop_seen;
            k.last = 1'b0;
            kept_expected.insert(kept_expected.size(), k);
            nkept++;
            for (int j = i + 1; j < n; j++) begin
                if (gone_flag[j]) continue;
                if (slot_cand[rank_slot[j]].cls != slot_cand[rank_slot[i]].cls) continue;
                if (iou_exceeds(slot_cand[rank_slot[i]], slot_cand[rank_slot[j]]))
                    gone_flag[j] = 1;
            end
        end
        if (nkept > 0) kept_expected[$].last = 1'b1;
        sets_closed++;
        if (drop_seen) overflow_sets++;
        foreach (gone_flag[i]) gone_flag[i] = 0;
        slot_count = 0;
        drop_seen = 0;
    endtask

    // candidate driver: a new transaction is offered once the last one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) absorb_candidate(cur_cand);
            if (!i_in_valid || !o_in_stall) begin
                if (pending_cands.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_cand = pending_cands.pop_front();
                    i_box_left        <= cur_cand.l;
                    i_box_top         <= cur_cand.t;
                    i_box_right       <= cur_cand.r;
                    i_box_bottom      <= cur_cand.b;
                    i_class_label     <= cur_cand.cls;
                    i_confidence      <= cur_cand.conf;
                    i_final_candidate <= cur_cand.fin;
                    i_in_valid        <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // kept box monitor and receiver stall
    always @(posedge i_clk) begin
        t_kept w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (kept_expected.size() == 0) begin
                report_mismatch("unexpected kept box, class", o_kept_class, 0);
            end else begin
                w = kept_expected.pop_front();
                boxes_checked++;
                if (o_kept_left !== w.l) report_mismatch("kept_left", o_kept_left, w.l);
                if (o_kept_top !== w.t) report_mismatch("kept_top", o_kept_top, w.t);
                if (o_kept_right !== w.r) report_mismatch("kept_right", o_kept_right, w.r);
                if (o_kept_bottom !== w.b) report_mismatch("kept_bottom", o_kept_bottom, w.b);
                if (o_kept_class !== w.cls) report_mismatch("kept_class", o_kept_class, w.cls);
                if (o_kept_confidence !== w.conf)
                    report_mismatch("kept_confidence", o_kept_confidence, w.conf);
                if (o_overflowed !== w.ovf) report_mismatch("overflowed", o_overflowed, w.ovf);
                if (o_last_kept !== w.last) report_mismatch("last_kept", o_last_kept, w.last);
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles, %0d kept boxes outstanding",
                     cycle_count, kept_expected.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_cand make_cand(input int l, t, r, b, cls, conf, fin);
        t_cand c;
        c.l = CW'(l); c.t = CW'(t); c.r = CW'(r); c.b = CW'(b);
        c.cls = LW'(cls); c.conf = CONF_BITS'(conf); c.fin = 1'(fin);
        return c;
    endfunction

    task automatic queue_cand(input t_cand c);
        pending_cands.insert(pending_cands.size(), c);
        items_queued++;
    endtask

    // random set: mostly jittered copies of one anchor box, some noise
    task automatic queue_random_set(input int n, input int nclass);
        t_cand c;
        int ax, ay, aw, ah, dx, dy;
        ax = $urandom_range(3800);
        ay = $urandom_range(3800);
        aw = $urandom_range(1, 250);
        ah = $urandom_range(1, 250);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 70) begin
                dx = $urandom_range(aw / 3 + 1);
                dy = $urandom_range(ah / 3 + 1);
                c.l = CW'(ax + dx);
                c.t = CW'(ay + dy);
                c.r = CW'(ax + dx + aw - int'($urandom_range(aw / 4)));
                c.b = CW'(ay + dy + ah - int'($urandom_range(ah / 4)));
                c.cls = LW'($urandom_range(nclass - 1));
            end else begin
                // full range noise, inverted boxes included
                c.l = CW'($urandom); c.t = CW'($urandom);
                c.r = CW'($urandom); c.b = CW'($urandom);
                c.cls = LW'($urandom);
            end
            // coarse confidences force ties now and then
            c.conf = ($urandom_range(3) == 0) ? 16'($urandom_range(4) * 16384) : 16'($urandom);
            c.fin = (i == n - 1);
            queue_cand(c);
        end
    endtask

    // wait for the block to go idle with nothing owed
    task automatic wait_drained();
        while (pending_cands.size() > 0 || i_in_valid || kept_expected.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= wr; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // transfer edge: prdata still holds the pre-edge value here
        if (!wr && addr[2] == REG_IOU_THR && prdata !== {16'd0, thr_shadow})
            report_mismatch("iou_threshold readback", prdata, thr_shadow);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [THR_BITS-1:0] thr);
        wait_drained();
        apb_access(1'b1, 3'd0, {16'hA5A5, thr});
        thr_shadow = thr;
        // unmapped register: must leave the threshold alone
        apb_access(1'b1, 3'd4, 32'h0000_1234);
        apb_access(1'b0, 3'd0, 32'd0);
    endtask

    task automatic run_random_phase(input int n_items, input int nclass);
        int stop;
        stop = items_queued + n_items;
        while (items_queued < stop)
            queue_random_set($urandom_range(1, 8), nclass);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset threshold, no idling
        apb_access(1'b0, 3'd0, 32'd0);
        queue_cand(make_cand(0, 0, 4095, 4095, 255, 65535, 1));          // lone extreme box
        queue_cand(make_cand(100, 100, 200, 200, 3, 500, 0));
        queue_cand(make_cand(100, 100, 200, 200, 3, 500, 0));            // exact tie, suppressed
        queue_cand(make_cand(200, 100, 300, 200, 3, 600, 0));            // touches only
        queue_cand(make_cand(100, 100, 200, 200, 4, 400, 0));            // other class
        queue_cand(make_cand(300, 300, 250, 350, 3, 65535, 0));          // inverted width
        queue_cand(make_cand(120, 300, 180, 250, 3, 0, 0));              // inverted height
        queue_cand(make_cand(105, 105, 205, 205, 3, 0, 1));              // zero conf, overlaps
        queue_cand(make_cand(4095, 4095, 4095, 4095, 0, 0, 1));          // degenerate box
        queue_cand(make_cand(0, 0, 10, 10, 7, 9, 0));
        queue_cand(make_cand(0, 0, 10, 10, 7, 9, 0));
        queue_cand(make_cand(1, 1, 11, 11, 7, 9, 1));                    // ties of one class
        wait_drained();

        // threshold zero: any real overlap suppresses, touching never does
        set_threshold(16'd0);
        queue_cand(make_cand(0, 0, 100, 100, 1, 1000, 0));
        queue_cand(make_cand(99, 99, 200, 200, 1, 900, 0));
        queue_cand(make_cand(100, 0, 200, 100, 1, 800, 0));
        queue_cand(make_cand(0, 100, 100, 200, 1, 800, 1));
        queue_cand(make_cand(0, 0, 4095, 4095, 2, 65535, 0));
        queue_cand(make_cand(4094, 4094, 4095, 4095, 2, 1, 1));
        run_random_phase(35, 2);

        // top threshold, sender idling
        set_threshold(16'hFFFF);
        send_idle_pct = 56; stall_pct = 0;
        queue_cand(make_cand(0, 0, 4095, 4095, 5, 100, 0));
        queue_cand(make_cand(0, 0, 4095, 4095, 5, 100, 1));              // full iou, suppressed
        run_random_phase(40, 3);

        // half threshold, receiver stalling, one set past capacity
        set_threshold(16'd32768);
        send_idle_pct = 0; stall_pct = 56;
        for (int i = 0; i < NBOX + 2; i++)
            queue_cand(make_cand($urandom_range(4000), $urandom_range(4000),
                                 $urandom_range(4095), $urandom_range(4095),
                                 $urandom_range(1), $urandom, i == NBOX + 1));
        // sender holds off until every kept box is back
        wait_drained();
        run_random_phase(25, 2);

        // random threshold, both sides idling
        set_threshold(16'($urandom));
        send_idle_pct = 27; stall_pct = 27;
        run_random_phase(30, 4);
        wait_drained();

        $display("closed %0d candidate sets (%0d past capacity), %0d kept boxes checked",
                 sets_closed, overflow_sets, boxes_checked);
        $display("thresholds at reset, zero, full scale, half and random; %0d mismatches",
                 err_count);
        if (err_count == 0 && kept_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/bnms_pkg.sv
rtl/bnms_ram.sv
rtl/bnms_iou.sv
rtl/box_non_max_suppression.sv
verif/testbench.sv
